@@ sv/skht_pkg.sv @@
// ----------------------------------------------------------------------------
// skht_pkg: shared types and constants of the sorted key/handle table
// Table depth, field widths, operation and status codes, cell and
// search-tree types.
// ----------------------------------------------------------------------------
package skht_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int CMD_W = 2;
    localparam int KEY_W = 64;
    localparam int HDL_W = 32;
    localparam int STS_W = 2;
    localparam int POS_W = 9;

    // Search tree: radix-8 leftmost-hit select, one register per level.
    localparam int TREE_FAN_W  = 3;
    localparam int TREE_FAN    = 1 << TREE_FAN_W;
    localparam int TREE_LVLS   = ($clog2(TABLE_DEPTH) + TREE_FAN_W - 1) / TREE_FAN_W;
    localparam int TREE_LEAVES = 1 << (TREE_FAN_W * TREE_LVLS);
    localparam int LVL_W       = $clog2(TREE_LVLS + 1);

    // Offset of a tree level in a flat array holding leaves first.
    function automatic int lvl_off(input int lvl);
        int off;
        off = 0;
        for (int j = 0; j < lvl; j++) begin
            off += TREE_LEAVES >> (TREE_FAN_W * j);
        end
        return off;
    endfunction

    localparam int TREE_NODES = lvl_off(TREE_LVLS + 1);

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STS_W-1:0] ST_BAD_KEY   = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        logic [HDL_W-1:0] handle_in;
    } t_item;

    typedef struct packed {
        logic [STS_W-1:0] status;
        logic [HDL_W-1:0] handle_out;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] entry_count;
    } t_result;

    // One table entry held by a cell.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [HDL_W-1:0] hdl;
    } t_ent;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic             by_hdl;  // search on handle (remove)
        logic             ins;     // insert at 'at', shift up
        logic             upd;     // rewrite handle at 'at'
        logic             rem;     // remove at 'at', shift down
        logic [IDX_W-1:0] at;
        logic [KEY_W-1:0] key;
        logic [HDL_W-1:0] hdl;
    } t_ctl;

    typedef struct packed {
        logic             flag;
        logic             eq;
        logic [HDL_W-1:0] hdl;
    } t_leaf;

    typedef struct packed {
        logic             found;
        logic             eq;
        logic [IDX_W-1:0] idx;
        logic [HDL_W-1:0] hdl;
    } t_node;

endpackage

@@ sv/skht_cell.sv @@
// ----------------------------------------------------------------------------
// skht_cell: one slot of the sorted row
// Holds one key/handle pair, compares it against the broadcast search
// operand and shifts up or down with its neighbors.
// ----------------------------------------------------------------------------
module skht_cell (
    input  logic                         i_clk,
    input  logic [skht_pkg::IDX_W-1:0]   i_idx,
    input  logic [skht_pkg::CNT_W-1:0]   i_cnt,
    input  skht_pkg::t_ctl               i_ctl,
    input  skht_pkg::t_ent               i_left,
    input  logic                         i_left_lt,
    input  skht_pkg::t_ent               i_right,
    output skht_pkg::t_ent               o_ent,
    output logic                         o_lt,
    output skht_pkg::t_leaf              o_leaf
);
    import skht_pkg::*;

    t_ent r_ent;
    logic w_valid;

    assign w_valid = CNT_W'(i_idx) < i_cnt;
    assign o_lt    = w_valid && (r_ent.key < i_ctl.key);
    assign o_ent   = r_ent;

    // Key search marks the sorted boundary; handle search marks every match.
    assign o_leaf.flag = i_ctl.by_hdl ? (w_valid && (r_ent.hdl == i_ctl.hdl))
                                      : (!o_lt && i_left_lt);
    assign o_leaf.eq   = w_valid && (r_ent.key == i_ctl.key);
    assign o_leaf.hdl  = r_ent.hdl;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (i_idx > i_ctl.at) begin
                r_ent <= i_left;
            end else if (i_idx == i_ctl.at) begin
                r_ent <= '{key: i_ctl.key, hdl: i_ctl.hdl};
            end
        end
        if (i_ctl.upd && (i_idx == i_ctl.at)) begin
            r_ent.hdl <= i_ctl.hdl;
        end
        if (i_ctl.rem && (i_idx >= i_ctl.at)) begin
            r_ent <= i_right;
        end
    end

endmodule

@@ sv/skht_tree.sv @@
// ----------------------------------------------------------------------------
// skht_tree: registered leftmost-hit search tree
// Reduces the per-cell flags to the lowest flagged slot, with its index,
// key-equal bit and handle; one register stage per radix-8 level.
// ----------------------------------------------------------------------------
module skht_tree (
    input  logic            i_clk,
    input  skht_pkg::t_leaf i_leaf [skht_pkg::TABLE_DEPTH],
    output skht_pkg::t_node o_root
);
    import skht_pkg::*;

    t_node w_leaf [TREE_LEAVES];
    t_node n_node [TREE_NODES - TREE_LEAVES];
    t_node r_node [TREE_NODES - TREE_LEAVES];

    for (genvar i = 0; i < TREE_LEAVES; i++) begin : g_leaf
        if (i < TABLE_DEPTH) begin : g_used
            assign w_leaf[i] = '{found: i_leaf[i].flag, eq: i_leaf[i].eq,
                                 idx: IDX_W'(i), hdl: i_leaf[i].hdl};
        end else begin : g_pad
            assign w_leaf[i] = '0;
        end
    end

    for (genvar l = 1; l <= TREE_LVLS; l++) begin : g_lvl
        localparam int NCNT  = TREE_LEAVES >> (TREE_FAN_W * l);
        localparam int BASE  = lvl_off(l) - TREE_LEAVES;
        localparam int CBASE = lvl_off(l - 1) - TREE_LEAVES;
        for (genvar n = 0; n < NCNT; n++) begin : g_node
            t_node w_kid [TREE_FAN];
            t_node w_pick;
            for (genvar c = 0; c < TREE_FAN; c++) begin : g_kid
                if (l == 1) begin : g_from_leaf
                    assign w_kid[c] = w_leaf[n * TREE_FAN + c];
                end else begin : g_from_node
                    assign w_kid[c] = r_node[CBASE + n * TREE_FAN + c];
                end
            end
            // lowest-indexed flagged child wins
            always_comb begin
                w_pick = w_kid[TREE_FAN-1];
                for (int c = TREE_FAN - 2; c >= 0; c--) begin
                    if (w_kid[c].found) begin
                        w_pick = w_kid[c];
                    end
                end
            end
            assign n_node[BASE + n] = w_pick;
        end
    end

    // all levels register together
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < TREE_NODES - TREE_LEAVES; k++) begin
            r_node[k] <= n_node[k];
        end
    end

    assign o_root = r_node[TREE_NODES - TREE_LEAVES - 1];

endmodule

@@ sv/sorted_key_handle_table_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_key_handle_table_unit: sorted key-to-handle table
// A row of TABLE_DEPTH cells kept in ascending key order, with lookup,
// insert/update and remove-by-handle operations.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_valid/o_ready, i_item): one operation per item,
//    cmd 0 lookup, 1 insert or update, 2 remove by handle.
//  - Output channel (o_valid/i_ready, o_result): exactly one result item
//    per input item, in order.
//  - Every cell compares itself with the operand in parallel. A registered
//    radix-8 tree picks the lowest flagged cell (TREE_LVLS stages, 3 at a
//    depth of 256), then the apply state shifts the row and loads the result.
//  - One item at a time: the next item is accepted only after the current
//    one has left the apply state.
//  - A result waiting on a stalled receiver does not block the next accept;
//    the following item then holds in its apply state until the output
//    register is free.
//  - Reset empties the table (entry count zero) at once; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_key_handle_table_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  skht_pkg::t_item   i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output skht_pkg::t_result o_result
);
    import skht_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SRCH  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [LVL_W-1:0] r_lvl;
    t_item            r_item;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid;
    t_result          r_result, n_result;

    // row wiring
    t_ent  w_ent  [TABLE_DEPTH];
    logic  w_lt   [TABLE_DEPTH];
    t_leaf w_leaf [TABLE_DEPTH];
    t_node w_root;
    t_ctl  w_ctl;

    logic w_go;
    logic w_key_op;
    logic w_hit;
    logic w_full;

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_result;

    // Apply only when the output register can take the result.
    assign w_go     = (r_state == S_APPLY) && (!r_out_valid || i_ready);
    assign w_key_op = (r_item.cmd == CMD_LOOKUP) || (r_item.cmd == CMD_INSERT);
    assign w_hit    = w_root.found && w_root.eq;
    assign w_full   = (r_count == CNT_W'(TABLE_DEPTH));

    // ---- cell row ----
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        t_ent w_left, w_right;
        logic w_left_lt;
        if (i == 0) begin : g_first
            assign w_left    = '0;
            assign w_left_lt = 1'b1;   // left edge acts as "smaller than key"
        end else begin : g_mid_l
            assign w_left    = w_ent[i-1];
            assign w_left_lt = w_lt[i-1];
        end
        if (i == TABLE_DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_ent[i+1];
        end

        skht_cell u_cell (
            .i_clk     (i_clk),
            .i_idx     (IDX_W'(i)),
            .i_cnt     (r_count),
            .i_ctl     (w_ctl),
            .i_left    (w_left),
            .i_left_lt (w_left_lt),
            .i_right   (w_right),
            .o_ent     (w_ent[i]),
            .o_lt      (w_lt[i]),
            .o_leaf    (w_leaf[i])
        );
    end

    skht_tree u_tree (
        .i_clk  (i_clk),
        .i_leaf (w_leaf),
        .o_root (w_root)
    );

    // ---- decision in the apply cycle ----
    always_comb begin
        w_ctl        = '0;
        w_ctl.by_hdl = (r_item.cmd == CMD_REMOVE);
        w_ctl.at     = w_root.idx;
        w_ctl.key    = r_item.key;
        w_ctl.hdl    = r_item.handle_in;

        n_count             = r_count;
        n_result.status     = ST_NOT_FOUND;
        n_result.handle_out = '0;
        n_result.position   = '0;

        if (w_key_op) begin
            if (r_item.key == '0) begin
                n_result.status = ST_BAD_KEY;
            end else if (w_hit) begin
                n_result.status   = ST_OK;
                n_result.position = POS_W'(w_root.idx);
                if (r_item.cmd == CMD_LOOKUP) begin
                    n_result.handle_out = w_root.hdl;
                end else begin
                    w_ctl.upd = w_go;
                end
            end else if (r_item.cmd == CMD_INSERT) begin
                if (w_full) begin
                    n_result.status = ST_FULL;
                end else begin
                    // boundary always exists while the row has a free slot
                    w_ctl.ins         = w_go;
                    n_count           = r_count + CNT_W'(1);
                    n_result.status   = ST_OK;
                    n_result.position = POS_W'(w_root.idx);
                end
            end
        end else if ((r_item.cmd == CMD_REMOVE) && w_root.found) begin
            w_ctl.rem         = w_go;
            n_count           = r_count - CNT_W'(1);
            n_result.status   = ST_OK;
            n_result.position = POS_W'(w_root.idx);
        end

        n_result.entry_count = POS_W'(n_count);
    end

    // ---- sequencer ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (r_lvl == LVL_W'(TREE_LVLS - 1)) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (w_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lvl       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SRCH) begin
                r_lvl <= r_lvl + LVL_W'(1);
            end else begin
                r_lvl <= '0;
            end
            if (w_go) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
        if (w_go) begin
            r_result <= n_result;
        end
    end

    // ---- checks ----
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && w_ctl.ins) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the table by one");

    a_boundary_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_APPLY) && w_key_op && (r_item.key != '0) && !w_full)
        |-> w_root.found)
        else $error("key search found no sorted boundary");

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: sorted key/handle table unit
// Directed and random operation streams run against a behavioral copy of the
// sorted table. Every result item is checked field by field, in order, under
// random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

    import skht_pkg::*;

    // Command code that the table does not decode: it must answer not found.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int TOTAL_ITEMS   = 1550;
    localparam int STALL_LIMIT   = 2000;   // cycles with no item moving either way
    localparam int DRAIN_CYCLES  = 20;     // plenty of margin after the last result
    localparam logic [KEY_W-1:0] KEY_MAX = '1;
    localparam logic [HDL_W-1:0] HDL_MAX = '1;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_valid = 1'b0;
    logic    o_ready;
    t_item   i_item  = '0;
    logic    o_valid;
    logic    i_ready = 1'b0;
    t_result o_result;

    sorted_key_handle_table_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow copy of the table, kept in sorted key order like the block.
    // Only entries below table_used are ever read.
    // ------------------------------------------------------------------------
    logic [KEY_W-1:0] table_keys [TABLE_DEPTH];
    logic [HDL_W-1:0] table_hdls [TABLE_DEPTH];
    int               table_used = 0;

    t_result pending_results [$];   // expected answers, oldest first
    int      items_sent   = 0;
    int      results_seen = 0;
    int      error_count  = 0;
    int      stall_cycles = 0;
    bit      steady_flow  = 1'b0;   // set: neither side idles

    // Apply one operation to the shadow table and return the answer.
    function automatic t_result table_apply(t_item op);
        t_result r;
        int      at;
        int      i;
        bit      hit;
        r.status     = ST_NOT_FOUND;
        r.handle_out = '0;
        r.position   = '0;
        case (op.cmd)
            CMD_LOOKUP, CMD_INSERT: begin
                if (op.key == '0) begin
                    r.status = ST_BAD_KEY;
                end else begin
                    // first slot whose key is not below the operand
                    at = 0;
                    while (at < table_used && table_keys[at] < op.key) at++;
                    hit = (at < table_used) && (table_keys[at] == op.key);
                    if (op.cmd == CMD_LOOKUP) begin
                        if (hit) begin
                            r.status     = ST_OK;
                            r.handle_out = table_hdls[at];
                            r.position   = POS_W'(at);
                        end
                    end else if (hit) begin
                        // existing key: handle rewrite, allowed even when full
                        table_hdls[at] = op.handle_in;
                        r.status       = ST_OK;
                        r.position     = POS_W'(at);
                    end else if (table_used >= TABLE_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        for (i = table_used; i > at; i--) begin
                            table_keys[i] = table_keys[i-1];
                            table_hdls[i] = table_hdls[i-1];
                        end
                        table_keys[at] = op.key;
                        table_hdls[at] = op.handle_in;
                        table_used++;
                        r.status   = ST_OK;
                        r.position = POS_W'(at);
                    end
                end
            end
            CMD_REMOVE: begin
                // lowest-positioned match only, then close the gap
                i = 0;
                while (i < table_used && table_hdls[i] != op.handle_in) i++;
                if (i < table_used) begin
                    r.status   = ST_OK;
                    r.position = POS_W'(i);
                    for (at = i; at + 1 < table_used; at++) begin
                        table_keys[at] = table_keys[at+1];
                        table_hdls[at] = table_hdls[at+1];
                    end
                    table_used--;
                end
            end
            default: ;
        endcase
        r.entry_count = POS_W'(table_used);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Operand pickers. Keys and handles lean on what the table holds so that
    // hits, updates and removes happen often; the rest mixes small, full-width and edge values.
    // ------------------------------------------------------------------------
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 40 && table_used > 0) return table_keys[$urandom_range(table_used - 1)];
        if (r < 65) return KEY_W'($urandom_range(300, 1));
        if (r < 90) return {$urandom, $urandom};
        if (r < 93) return KEY_MAX;
        if (r < 96) return KEY_W'(1);
        return '0;
    endfunction

    function automatic logic [HDL_W-1:0] pick_handle();
        int r;
        r = $urandom_range(99);
        if (r < 40 && table_used > 0) return table_hdls[$urandom_range(table_used - 1)];
        if (r < 70) return HDL_W'($urandom_range(15));   // small pool: duplicates
        return $urandom;
    endfunction

    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        k = {$urandom, $urandom};
        return (k == '0) ? KEY_W'(1) : k;
    endfunction

    function automatic t_item make_op(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
                                      logic [HDL_W-1:0] h);
        t_item it;
        it.cmd       = c;
        it.key       = k;
        it.handle_in = h;
        return it;
    endfunction

    // Mixed random operation with the given percentages of lookup/insert/remove;
    // what is left over goes to the unused command.
    function automatic t_item random_op(int pct_lookup, int pct_insert, int pct_remove);
        int r;
        r = $urandom_range(99);
        if (r < pct_lookup)
            return make_op(CMD_LOOKUP, pick_key(), $urandom);
        if (r < pct_lookup + pct_insert)
            return make_op(CMD_INSERT, pick_key(), pick_handle());
        if (r < pct_lookup + pct_insert + pct_remove)
            return make_op(CMD_REMOVE, {$urandom, $urandom}, pick_handle());
        return make_op(CMD_UNUSED, {$urandom, $urandom}, $urandom);
    endfunction

    // ------------------------------------------------------------------------
    // Sender: optional idle gap, then hold the item until accepted. Inputs
    // move on the falling edge; acceptance is judged at the rising edge.
    // ------------------------------------------------------------------------
    task automatic send_item(t_item it);
        int gap;
        if (!steady_flow && $urandom_range(99) < 19) begin
            gap = $urandom_range(4, 1);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (!o_ready);
        pending_results.insert(pending_results.size(), table_apply(it));
        items_sent++;
    endtask

    // Receiver: ready drops at random unless a steady stretch is running.
    always @(negedge i_clk) begin
        i_ready <= steady_flow || ($urandom_range(99) >= 19);
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on result %0d: %s got %0h, expected %0h",
                 results_seen, what, got, want);
        error_count++;
    endtask

    // Checker: each result item against the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected item", 64'(o_result), 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_result.status !== want.status)
                    report_mismatch("status", 64'(o_result.status), 64'(want.status));
                if (o_result.handle_out !== want.handle_out)
                    report_mismatch("handle_out", 64'(o_result.handle_out),
                                    64'(want.handle_out));
                if (o_result.position !== want.position)
                    report_mismatch("position", 64'(o_result.position),
                                    64'(want.position));
                if (o_result.entry_count !== want.entry_count)
                    report_mismatch("entry_count", 64'(o_result.entry_count),
                                    64'(want.entry_count));
            end
            results_seen++;
        end
    end

    // Watchdog: too long with no item moving on either channel ends the run.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Extremes and special cases, each in a known table state.
    task automatic test_directed();
        send_item(make_op(CMD_LOOKUP, 64'd5, '0));                   // empty table
        send_item(make_op(CMD_LOOKUP, '0, '0));                      // zero key lookup
        send_item(make_op(CMD_INSERT, '0, 32'h1111_2222));           // zero key insert
        send_item(make_op(CMD_REMOVE, '0, '0));                      // remove on empty
        send_item(make_op(CMD_UNUSED, '0, '0));                      // unused command
        send_item(make_op(CMD_INSERT, KEY_MAX, HDL_MAX));            // top key
        send_item(make_op(CMD_INSERT, 64'd1, '0));                   // lowest key, handle 0
        send_item(make_op(CMD_INSERT, 64'h8000_0000_0000_0000, 32'd7));
        send_item(make_op(CMD_INSERT, 64'h100, 32'd7));              // duplicate handle
        send_item(make_op(CMD_LOOKUP, 64'd1, '0));
        send_item(make_op(CMD_LOOKUP, KEY_MAX, '0));
        send_item(make_op(CMD_LOOKUP, 64'd2, '0));                   // absent key
        send_item(make_op(CMD_INSERT, 64'h100, 32'hA5A5_A5A5));      // update
        send_item(make_op(CMD_INSERT, 64'h80, 32'd7));               // lands mid-table
        send_item(make_op(CMD_REMOVE, '0, 32'd7));                   // lowest of two matches
        send_item(make_op(CMD_REMOVE, KEY_MAX, '0));                 // handle zero is real
        send_item(make_op(CMD_REMOVE, '0, 32'h1234));                // absent handle
        send_item(make_op(CMD_UNUSED, KEY_MAX, HDL_MAX));
        send_item(make_op(CMD_LOOKUP, 64'h8000_0000_0000_0000, '0));
        send_item(make_op(CMD_INSERT, 64'h100, '0));
        send_item(make_op(CMD_REMOVE, '0, HDL_MAX));                 // drops the top key
        send_item(make_op(CMD_LOOKUP, 64'h100, HDL_MAX));
    endtask

    // General mix; the first stretch runs with both sides never idling.
    task automatic test_random_mix(int n);
        for (int i = 0; i < n; i++) begin
            steady_flow = (i < 150);
            send_item(random_op(35, 35, 25));
        end
        steady_flow = 1'b0;
    endtask

    // Grow the table to full, then hammer it: new keys must be refused,
    // updates of held keys still pass, a remove reopens one slot.
    task automatic test_fill_to_full();
        t_item op;
        while (table_used < TABLE_DEPTH) begin
            if ($urandom_range(99) < 85)
                op = make_op(CMD_INSERT, fresh_key(), $urandom);
            else
                op = random_op(40, 30, 20);
            send_item(op);
        end
        for (int i = 0; i < 150; i++) begin
            case ($urandom_range(5))
                0, 1:    op = make_op(CMD_INSERT, fresh_key(), $urandom);
                2:       op = make_op(CMD_INSERT, pick_key(), pick_handle());
                3:       op = make_op(CMD_LOOKUP, pick_key(), $urandom);
                4:       op = make_op(CMD_REMOVE, fresh_key(), pick_handle());
                default: op = make_op(CMD_INSERT, fresh_key(), $urandom);
            endcase
            send_item(op);
        end
    endtask

    // Empty the table mostly through removes of held handles.
    task automatic test_drain_to_empty();
        t_item op;
        while (table_used > 0) begin
            if ($urandom_range(99) < 85)
                op = make_op(CMD_REMOVE, {$urandom, $urandom},
                             table_hdls[$urandom_range(table_used - 1)]);
            else
                op = random_op(50, 10, 30);
            send_item(op);
        end
        for (int i = 0; i < 10; i++) send_item(random_op(30, 20, 45));
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_mix(500);
        test_fill_to_full();
        test_drain_to_empty();
        test_random_mix((TOTAL_ITEMS > items_sent) ? TOTAL_ITEMS - items_sent : 50);

        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/skht_pkg.sv
sv/skht_cell.sv
sv/skht_tree.sv
sv/sorted_key_handle_table_unit.sv
verif/testbench.sv
